// ===== rtl/ckmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckmp_pkg
// Shared types, constants and helpers of the case-insensitive KMP matcher.
// ----------------------------------------------------------------------------
package ckmp_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int IDX_W       = $clog2(MAX_PATTERN + 1);
    localparam int PIDX_W      = $clog2(MAX_PATTERN);
    localparam int CHAR_W      = 8;
    localparam int PAT_BITS    = MAX_PATTERN * CHAR_W;
    localparam int LINE_W      = 24;
    localparam int COL_W       = 16;
    localparam int TOTAL_W     = 32;
    localparam int LEN_REG_W   = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [LINE_W-1:0]  LINE_MAX  = '1;
    localparam logic [COL_W-1:0]   COL_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    localparam logic [CHAR_W-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LOW      = 3'd0,
        REG_PAT_MID_LOW  = 3'd1,
        REG_PAT_MID_HIGH = 3'd2,
        REG_PAT_HIGH     = 3'd3,
        REG_PAT_LEN      = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        B_IDLE,
        B_START,
        B_GET_C,
        B_CMP
    } t_build_state;

    typedef enum logic [1:0] {
        K_IDLE,
        K_WALK,
        K_FIN
    } t_back_state;

    typedef struct packed {
        logic              eol;
        logic [CHAR_W-1:0] ch;
    } t_item;

    typedef struct packed {
        logic               matched;
        logic [LINE_W-1:0]  line;
        logic [COL_W-1:0]   column;
        logic [TOTAL_W-1:0] total;
    } t_result;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_lookup_req;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  fail;
    } t_lookup_rsp;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] active_length(input logic [LEN_REG_W-1:0] v);
        logic [IDX_W-1:0] r;
        if (v == '0) begin
            r = IDX_W'(1);
        end else if (v > LEN_REG_W'(MAX_PATTERN)) begin
            r = IDX_W'(MAX_PATTERN);
        end else begin
            r = IDX_W'(v);
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] pattern_at(input logic [PAT_BITS-1:0] pat,
                                                     input logic [IDX_W-1:0]    idx);
        logic [PIDX_W-1:0] p;
        p = idx[PIDX_W-1:0];
        return fold_case(pat[p * CHAR_W +: CHAR_W]);
    endfunction

endpackage

// ===== rtl/ckmp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckmp_front
// Accepts requests, folds case, tags end of line and queues them for the back.
// ----------------------------------------------------------------------------
module ckmp_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic                        i_op,
    input  logic [ckmp_pkg::CHAR_W-1:0] i_text_byte,
    output logic                        o_full,
    output logic                        o_item_valid,
    output ckmp_pkg::t_item             o_item,
    input  logic                        i_item_pop
);
    import ckmp_pkg::*;

    t_item              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd, n_rd;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic               wr_en;
    logic               rd_en;
    t_item              item;

    always_comb begin
        item.eol = (i_op == OP_EOL);
        item.ch  = item.eol ? '0 : fold_case(i_text_byte);
    end

    assign o_full       = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rd];
    assign wr_en        = i_push && !o_full;
    assign rd_en        = i_item_pop && o_item_valid;

    always_comb begin
        n_wr  = wr_en ? r_wr + 1'b1 : r_wr;
        n_rd  = rd_en ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= item;
        end
    end

endmodule

// ===== rtl/ckmp_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckmp_table
// Failure table memory, its builder, and the shared pattern/table lookup port.
// ----------------------------------------------------------------------------
module ckmp_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rebuild,
    input  logic [ckmp_pkg::PAT_BITS-1:0] i_pattern,
    input  logic [ckmp_pkg::IDX_W-1:0]    i_length,
    output logic                          o_ready,
    input  ckmp_pkg::t_lookup_req         i_lk_req,
    output ckmp_pkg::t_lookup_rsp         o_lk_rsp
);
    import ckmp_pkg::*;

    // entry n (n >= 2) lives at n-1; entries 0 and 1 read as zero
    logic [IDX_W-1:0]  r_mem [MAX_PATTERN];
    logic [CHAR_W-1:0] r_rd_ch;
    logic [IDX_W-1:0]  r_rd_fail;
    logic              r_rd_zero;

    t_build_state      r_bstate, n_bstate;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [IDX_W-1:0]  r_k, n_k;
    logic [CHAR_W-1:0] r_c, n_c;

    logic              bld_en;
    logic [IDX_W-1:0]  bld_idx;
    logic              lk_en;
    logic [IDX_W-1:0]  lk_idx;
    logic [IDX_W-1:0]  lk_dec;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_data;
    logic [IDX_W-1:0]  k_next;
    logic [IDX_W-1:0]  i_next;

    assign o_lk_rsp.ch   = r_rd_ch;
    assign o_lk_rsp.fail = r_rd_zero ? '0 : r_rd_fail;
    assign o_ready       = (r_bstate == B_IDLE);

    assign lk_en  = (r_bstate == B_IDLE) ? i_lk_req.en  : bld_en;
    assign lk_idx = (r_bstate == B_IDLE) ? i_lk_req.idx : bld_idx;
    assign lk_dec = lk_idx - 1'b1;
    assign i_next = r_i + 1'b1;

    always_comb begin
        n_bstate = r_bstate;
        n_i      = r_i;
        n_k      = r_k;
        n_c      = r_c;
        bld_en   = 1'b0;
        bld_idx  = r_k;
        wr_en    = 1'b0;
        wr_data  = '0;
        k_next   = '0;
        unique case (r_bstate)
            B_IDLE: begin
            end
            B_START: begin
                n_i = IDX_W'(1);
                n_k = '0;
                if (i_length <= IDX_W'(1)) begin
                    n_bstate = B_IDLE;
                end else begin
                    bld_en   = 1'b1;
                    bld_idx  = IDX_W'(1);
                    n_bstate = B_GET_C;
                end
            end
            B_GET_C: begin
                n_c      = o_lk_rsp.ch;
                bld_en   = 1'b1;
                bld_idx  = r_k;
                n_bstate = B_CMP;
            end
            B_CMP: begin
                if (r_c == o_lk_rsp.ch || r_k == '0) begin
                    k_next  = (r_c == o_lk_rsp.ch) ? r_k + 1'b1 : '0;
                    wr_en   = 1'b1;
                    wr_data = k_next;
                    n_k     = k_next;
                    n_i     = i_next;
                    if (i_next >= i_length) begin
                        n_bstate = B_IDLE;
                    end else begin
                        bld_en   = 1'b1;
                        bld_idx  = i_next;
                        n_bstate = B_GET_C;
                    end
                end else begin
                    n_k     = o_lk_rsp.fail;
                    bld_en  = 1'b1;
                    bld_idx = o_lk_rsp.fail;
                end
            end
            default: begin
                n_bstate = B_START;
            end
        endcase
        if (i_rebuild) begin
            n_bstate = B_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate <= B_START;
        end else begin
            r_bstate <= n_bstate;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_k <= n_k;
        r_c <= n_c;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_i[PIDX_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lk_en) begin
            r_rd_ch   <= pattern_at(i_pattern, lk_idx);
            r_rd_fail <= r_mem[lk_dec[PIDX_W-1:0]];
            r_rd_zero <= (lk_idx < IDX_W'(2));
        end
    end

endmodule

// ===== rtl/ckmp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckmp_back
// KMP walk per text byte, line/column/total counters and the result queue.
// ----------------------------------------------------------------------------
module ckmp_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rebuild,
    input  logic [ckmp_pkg::IDX_W-1:0]   i_length,
    input  logic                         i_table_ready,
    input  logic                         i_item_valid,
    input  ckmp_pkg::t_item              i_item,
    output logic                         o_item_pop,
    output ckmp_pkg::t_lookup_req        o_lk_req,
    input  ckmp_pkg::t_lookup_rsp        i_lk_rsp,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic                         o_matched,
    output logic [ckmp_pkg::LINE_W-1:0]  o_match_line,
    output logic [ckmp_pkg::COL_W-1:0]   o_match_column,
    output logic [ckmp_pkg::TOTAL_W-1:0] o_total_matches
);
    import ckmp_pkg::*;

    t_back_state        r_state, n_state;
    logic [IDX_W-1:0]   r_mlen, n_mlen;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [CHAR_W-1:0]  r_c, n_c;
    logic [COL_W-1:0]   r_col, n_col;
    logic [LINE_W-1:0]  r_line, n_line;
    logic [TOTAL_W-1:0] r_total, n_total;

    t_result            r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               q_full;
    logic               res_push;
    logic               res_pop;
    t_result            res;

    logic [IDX_W-1:0]   j_inc;
    logic [COL_W-1:0]   len_col;
    logic [COL_W-1:0]   start_col;

    assign q_full    = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign res_pop   = i_pop && !o_empty;
    assign j_inc     = r_j + 1'b1;
    assign len_col   = COL_W'(i_length);
    assign start_col = (r_col >= len_col) ? r_col - len_col + 1'b1 : COL_W'(1);

    assign o_matched       = r_q[r_rd].matched;
    assign o_match_line    = r_q[r_rd].line;
    assign o_match_column  = r_q[r_rd].column;
    assign o_total_matches = r_q[r_rd].total;

    always_comb begin
        n_state      = r_state;
        n_mlen       = r_mlen;
        n_j          = r_j;
        n_c          = r_c;
        n_col        = r_col;
        n_line       = r_line;
        n_total      = r_total;
        o_item_pop   = 1'b0;
        o_lk_req.en  = 1'b0;
        o_lk_req.idx = r_j;
        res_push     = 1'b0;
        res.matched  = 1'b0;
        res.line     = r_line;
        res.column   = '0;
        res.total    = r_total;
        unique case (r_state)
            K_IDLE: begin
                if (i_item_valid && i_table_ready && !q_full) begin
                    o_item_pop = 1'b1;
                    if (i_item.eol) begin
                        n_mlen   = '0;
                        n_col    = '0;
                        n_line   = (r_line != LINE_MAX) ? r_line + 1'b1 : r_line;
                        res.line = n_line;
                        res_push = 1'b1;
                    end else begin
                        n_c          = i_item.ch;
                        n_j          = (r_mlen >= i_length) ? '0 : r_mlen;
                        n_col        = (r_col != COL_MAX) ? r_col + 1'b1 : r_col;
                        o_lk_req.en  = 1'b1;
                        o_lk_req.idx = n_j;
                        n_state      = K_WALK;
                    end
                end
            end
            K_WALK: begin
                if (r_c == i_lk_rsp.ch) begin
                    if (j_inc >= i_length) begin
                        n_total      = (r_total != TOTAL_MAX) ? r_total + 1'b1 : r_total;
                        o_lk_req.en  = 1'b1;
                        o_lk_req.idx = i_length;
                        n_state      = K_FIN;
                    end else begin
                        n_mlen   = j_inc;
                        res_push = 1'b1;
                        n_state  = K_IDLE;
                    end
                end else if (r_j == '0) begin
                    n_mlen   = '0;
                    res_push = 1'b1;
                    n_state  = K_IDLE;
                end else begin
                    n_j          = i_lk_rsp.fail;
                    o_lk_req.en  = 1'b1;
                    o_lk_req.idx = i_lk_rsp.fail;
                end
            end
            K_FIN: begin
                n_mlen      = i_lk_rsp.fail;
                res.matched = 1'b1;
                res.column  = start_col;
                res_push    = 1'b1;
                n_state     = K_IDLE;
            end
            default: begin
                n_state = K_IDLE;
            end
        endcase
        if (i_rebuild) begin
            n_mlen = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= K_IDLE;
            r_mlen  <= '0;
            r_col   <= '0;
            r_line  <= LINE_W'(1);
            r_total <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_mlen  <= n_mlen;
            r_col   <= n_col;
            r_line  <= n_line;
            r_total <= n_total;
            if (res_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (res_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (res_push && !res_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (res_pop && !res_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j <= n_j;
        r_c <= n_c;
        if (res_push) begin
            r_q[r_wr] <= res;
        end
    end

endmodule

// ===== rtl/case_insensitive_kmp_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// case_insensitive_kmp_matcher
// Streaming case-insensitive pattern search with line/column match reports.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+------------------------
//  text     | in        | push / full                 | i_op, i_text_byte
//  result   | out       | empty / pop                 | o_matched, o_match_line,
//           |           |                             | o_match_column,
//           |           |                             | o_total_matches
//  config   | in        | psel, penable, pwrite/pready | paddr, pwdata, prdata
//
// In the back end a text byte passes the idle and walk states, stays in walk
// for each failure step and visits the finish state when it completes a match;
// an end of line is handled in the idle state alone. Failure steps go through
// the single lookup port on the failure table. After reset and after each write
// to a pattern or length register the table is rebuilt; requests queue meanwhile.
// Reset is synchronous; a full result queue stops the back end, so text then queues up.
// ----------------------------------------------------------------------------
module case_insensitive_kmp_matcher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_op,
    input  logic [ckmp_pkg::CHAR_W-1:0]     i_text_byte,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_matched,
    output logic [ckmp_pkg::LINE_W-1:0]     o_match_line,
    output logic [ckmp_pkg::COL_W-1:0]      o_match_column,
    output logic [ckmp_pkg::TOTAL_W-1:0]    o_total_matches,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ckmp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ckmp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ckmp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import ckmp_pkg::*;

    logic [CFG_DATA_W-1:0] r_pat [4];
    logic [LEN_REG_W-1:0]  r_len;
    logic                  cfg_wr;
    logic                  rebuild;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [PAT_BITS-1:0]   pattern;
    logic [IDX_W-1:0]      length;

    logic                  item_valid;
    t_item                 item;
    logic                  item_pop;
    logic                  tbl_ready;
    t_lookup_req           lk_req;
    t_lookup_rsp           lk_rsp;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W];
    assign pattern = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};
    assign length  = active_length(r_len);

    always_comb begin
        rebuild = 1'b0;
        prdata  = '0;
        case (cfg_idx)
            REG_PAT_LOW: begin
                rebuild = cfg_wr;
                prdata  = r_pat[0];
            end
            REG_PAT_MID_LOW: begin
                rebuild = cfg_wr;
                prdata  = r_pat[1];
            end
            REG_PAT_MID_HIGH: begin
                rebuild = cfg_wr;
                prdata  = r_pat[2];
            end
            REG_PAT_HIGH: begin
                rebuild = cfg_wr;
                prdata  = r_pat[3];
            end
            REG_PAT_LEN: begin
                rebuild = cfg_wr;
                prdata  = CFG_DATA_W'(r_len);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat[0] <= '0;
            r_pat[1] <= '0;
            r_pat[2] <= '0;
            r_pat[3] <= '0;
            r_len    <= LEN_REG_W'(1);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PAT_LOW:      r_pat[0] <= pwdata;
                REG_PAT_MID_LOW:  r_pat[1] <= pwdata;
                REG_PAT_MID_HIGH: r_pat[2] <= pwdata;
                REG_PAT_HIGH:     r_pat[3] <= pwdata;
                REG_PAT_LEN:      r_len    <= pwdata[LEN_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ckmp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_op         (i_op),
        .i_text_byte  (i_text_byte),
        .o_full       (full),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    ckmp_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rebuild (rebuild),
        .i_pattern (pattern),
        .i_length  (length),
        .o_ready   (tbl_ready),
        .i_lk_req  (lk_req),
        .o_lk_rsp  (lk_rsp)
    );

    ckmp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rebuild       (rebuild),
        .i_length        (length),
        .i_table_ready   (tbl_ready),
        .i_item_valid    (item_valid),
        .i_item          (item),
        .o_item_pop      (item_pop),
        .o_lk_req        (lk_req),
        .i_lk_rsp        (lk_rsp),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_matched       (o_matched),
        .o_match_line    (o_match_line),
        .o_match_column  (o_match_column),
        .o_total_matches (o_total_matches)
    );

`ifndef SYNTHESIS
    a_col_iff_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_matched == (o_match_column != '0)))
        else $error("start column disagrees with match flag");

    a_pop_needs_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_pop |-> tbl_ready)
        else $error("request taken while failure table rebuilds");

    a_lookup_needs_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lk_req.en |-> tbl_ready)
        else $error("back end lookup during table rebuild");
`endif

endmodule

// ===== bench/kmp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_checker
// Watches the text, result and register channels of the case-insensitive
// KMP matcher. Keeps its own copy of the pattern registers and failure links,
// predicts one result per accepted request and compares each popped result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module kmp_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic                            i_full,
    input  logic                            i_op,
    input  logic [ckmp_pkg::CHAR_W-1:0]     i_text_byte,
    input  logic                            i_empty,
    input  logic                            i_pop,
    input  logic                            i_matched,
    input  logic [ckmp_pkg::LINE_W-1:0]     i_match_line,
    input  logic [ckmp_pkg::COL_W-1:0]      i_match_column,
    input  logic [ckmp_pkg::TOTAL_W-1:0]    i_total_matches,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [ckmp_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  logic [ckmp_pkg::CFG_DATA_W-1:0] i_pwdata,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_results,
    output int                              o_hits
);
    import ckmp_pkg::*;

    logic [PAT_BITS-1:0]  pat_bits;
    logic [LEN_REG_W-1:0] len_field;
    logic [IDX_W-1:0]     fail_link [0:MAX_PATTERN];
    int unsigned          progress;
    logic [COL_W-1:0]     column_pos;
    logic [LINE_W-1:0]    line_no;
    logic [TOTAL_W-1:0]   hit_total;
    t_result              expected_q [$];
    int                   err_count = 0;
    int                   result_count = 0;
    int                   hit_count = 0;

    function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] key_char(input int unsigned idx);
        return to_lower(pat_bits[(idx % MAX_PATTERN) * CHAR_W +: CHAR_W]);
    endfunction

    function automatic int unsigned key_length();
        if (len_field == 0) begin
            return 1;
        end
        if (len_field > MAX_PATTERN) begin
            return MAX_PATTERN;
        end
        return len_field;
    endfunction

    function automatic void rebuild_links();
        int unsigned n;
        int unsigned k;
        n = key_length();
        k = 0;
        for (int i = 0; i <= MAX_PATTERN; i++) begin
            fail_link[i] = '0;
        end
        for (int unsigned i = 1; i < n; i++) begin
            while (k > 0 && key_char(i) != key_char(k)) begin
                k = fail_link[k];
            end
            if (key_char(i) == key_char(k)) begin
                k++;
            end
            fail_link[i + 1] = IDX_W'(k);
        end
        progress = 0;
    endfunction

    function automatic void reset_model();
        pat_bits   = '0;
        len_field  = LEN_REG_W'(1);
        column_pos = '0;
        line_no    = LINE_W'(1);
        hit_total  = '0;
        rebuild_links();
    endfunction

    function automatic void write_register(input logic [CFG_ADDR_W-1:0] addr,
                                           input logic [CFG_DATA_W-1:0] data);
        t_reg_idx idx;
        idx = t_reg_idx'(addr[CFG_ADDR_W-1 -: CFG_IDX_W]);
        case (idx)
            REG_PAT_LOW, REG_PAT_MID_LOW, REG_PAT_MID_HIGH, REG_PAT_HIGH: begin
                pat_bits[int'(idx) * CFG_DATA_W +: CFG_DATA_W] = data;
            end
            REG_PAT_LEN: begin
                len_field = data[LEN_REG_W-1:0];
            end
            default: begin
                return;
            end
        endcase
        rebuild_links();
    endfunction

    function automatic t_result scan_request(input logic op, input logic [CHAR_W-1:0] raw);
        t_result           r;
        logic [CHAR_W-1:0] c;
        int unsigned       n;
        int unsigned       j;
        c = to_lower(raw);
        n = key_length();
        r = '0;
        if (op == OP_EOL) begin
            progress   = 0;
            column_pos = '0;
            if (line_no != LINE_MAX) begin
                line_no++;
            end
        end else begin
            j = (progress >= n) ? 0 : progress;
            if (column_pos != COL_MAX) begin
                column_pos++;
            end
            while (j != 0 && c != key_char(j)) begin
                j = fail_link[j];
            end
            if (c == key_char(j)) begin
                j++;
            end
            if (j >= n) begin
                r.matched = 1'b1;
                if (hit_total != TOTAL_MAX) begin
                    hit_total++;
                end
                // start column is clamped to 1 when the column count is below the pattern length
                r.column = (column_pos >= n) ? COL_W'(column_pos - n + 1) : COL_W'(1);
                j = fail_link[n];
            end
            progress = j;
        end
        r.line  = line_no;
        r.total = hit_total;
        return r;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            reset_model();
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                write_register(i_paddr, i_pwdata);
            end
            if (i_pop && !i_empty) begin
                result_count++;
                if (expected_q.size() == 0) begin
                    $error("result popped with no request outstanding");
                    err_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("matched", want.matched, i_matched);
                    check_field("match_line", want.line, i_match_line);
                    check_field("match_column", want.column, i_match_column);
                    check_field("total_matches", want.total, i_total_matches);
                end
            end
            if (i_push && !i_full) begin
                want = scan_request(i_op, i_text_byte);
                hit_count += want.matched;
                expected_q.push_back(want);
            end
        end
        o_errors  <= err_count;
        o_pending <= expected_q.size();
        o_results <= result_count;
        o_hits    <= hit_count;
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the case-insensitive KMP matcher. A short directed sequence
// covers case folding, overlapping matches and end of line; then random
// phases with pattern lengths from 0 to 63 and four idle mixes on the text
// and result queues; last, a short line of overlapping pattern copies.
// Checking is done by kmp_checker.
// ----------------------------------------------------------------------------
module testbench;
    import ckmp_pkg::*;

    localparam int RAND_PHASES     = 8;
    localparam int IDLE_MODES      = 4;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int LONG_LINE       = 24;
    localparam int SETTLE_CYCLES   = 100;

    localparam logic [CHAR_W-1:0] CH_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_B = 8'h62;
    localparam logic [CHAR_W-1:0] CH_Z = 8'h7A;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  op = OP_TEXT;
    logic [CHAR_W-1:0]     text_byte = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  matched;
    logic [LINE_W-1:0]     match_line;
    logic [COL_W-1:0]      match_column;
    logic [TOTAL_W-1:0]    total_matches;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int result_total;
    int hit_total;

    int                  send_idle_pct = 0;
    int                  pop_stall_pct = 0;
    int                  request_count = 0;
    int                  settings_used = 0;
    logic [PAT_BITS-1:0] key_bits;
    int unsigned         key_len = 1;

    always #4 clk = ~clk;

    case_insensitive_kmp_matcher u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .push            (push),
        .full            (full),
        .i_op            (op),
        .i_text_byte     (text_byte),
        .empty           (empty),
        .pop             (pop),
        .o_matched       (matched),
        .o_match_line    (match_line),
        .o_match_column  (match_column),
        .o_total_matches (total_matches),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    kmp_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_op            (op),
        .i_text_byte     (text_byte),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_matched       (matched),
        .i_match_line    (match_line),
        .i_match_column  (match_column),
        .i_total_matches (total_matches),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_errors        (fail_count),
        .o_pending       (pending),
        .o_results       (result_total),
        .o_hits          (hit_total)
    );

    always @(posedge clk) begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    task automatic set_idle(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  pop_stall_pct <= 0;  end
            1: begin send_idle_pct = 79; pop_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct <= 79; end
            default: begin send_idle_pct = 37; pop_stall_pct <= 37; end
        endcase
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(int'(idx) * 8);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_pattern(input logic [PAT_BITS-1:0] bits,
                                input logic [LEN_REG_W-1:0] len_field);
        logic [CFG_DATA_W-1:0] len_word;
        len_word = {$urandom, $urandom};
        len_word[LEN_REG_W-1:0] = len_field;
        write_reg(REG_PAT_LOW, bits[0 +: CFG_DATA_W]);
        write_reg(REG_PAT_MID_LOW, bits[CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PAT_MID_HIGH, bits[2 * CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PAT_HIGH, bits[3 * CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PAT_LEN, len_word);
        key_bits = bits;
        if (len_field == 0) begin
            key_len = 1;
        end else if (len_field > MAX_PATTERN) begin
            key_len = MAX_PATTERN;
        end else begin
            key_len = len_field;
        end
        settings_used++;
    endtask

    task automatic send(input logic kind, input logic [CHAR_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        op        <= kind;
        text_byte <= value;
        do @(posedge clk); while (full);
        request_count++;
    endtask

    // sender holds off until every outstanding request has its result
    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [CHAR_W-1:0] any_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] lc;
        lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
        if (lc >= CH_A && lc <= CH_Z && $urandom_range(1) == 1) begin
            return lc - CASE_OFFSET;
        end
        return lc;
    endfunction

    function automatic logic [CHAR_W-1:0] key_byte(input int unsigned idx);
        return key_bits[idx * CHAR_W +: CHAR_W];
    endfunction

    task automatic pick_pattern(input int phase);
        logic [PAT_BITS-1:0]  bits;
        logic [LEN_REG_W-1:0] len_field;
        int unsigned          n;
        for (int w = 0; w < PAT_BITS / 32; w++) begin
            bits[w * 32 +: 32] = $urandom;
        end
        case (phase % 8)
            0: len_field = '0;
            1: begin
                for (int i = 0; i < MAX_PATTERN; i++) begin
                    bits[i * CHAR_W +: CHAR_W] = any_case((i % 2 == 1) ? CH_B : CH_A);
                end
                len_field = LEN_REG_W'(MAX_PATTERN);
            end
            2: begin
                bits      = '1;
                len_field = '1;
            end
            3: begin
                n = $urandom_range(6, 2);
                for (int i = 0; i < n; i++) begin
                    bits[i * CHAR_W +: CHAR_W] = any_case(($urandom_range(1) == 1) ? CH_B : CH_A);
                end
                len_field = LEN_REG_W'(n);
            end
            4: begin
                n = $urandom_range(20, 7);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(4))
                        0: bits[i * CHAR_W +: CHAR_W] = any_case(CH_A);
                        1: bits[i * CHAR_W +: CHAR_W] = any_case(CH_B);
                        2: bits[i * CHAR_W +: CHAR_W] = 8'h00;
                        3: bits[i * CHAR_W +: CHAR_W] = 8'hFF;
                        default: bits[i * CHAR_W +: CHAR_W] = CH_UPPER_A - 1;
                    endcase
                end
                len_field = LEN_REG_W'(n);
            end
            5: begin
                bits = '0;
                bits[CHAR_W-1:0] = CH_UPPER_Z;
                len_field = LEN_REG_W'(1);
            end
            6: len_field = LEN_REG_W'($urandom_range(MAX_PATTERN, 1));
            default: begin
                n = $urandom_range(12, 2);
                for (int i = 0; i < n; i++) begin
                    bits[i * CHAR_W +: CHAR_W] = any_case(CH_A);
                end
                bits[(n - 1) * CHAR_W +: CHAR_W] = any_case(CH_B);
                len_field = LEN_REG_W'(n);
            end
        endcase
        load_pattern(bits, len_field);
    endtask

    // mostly whole or cut-short pattern copies, with stray bytes and line breaks
    task automatic random_text(input int count);
        int          sent;
        int          r;
        int unsigned cut;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(99);
            if (r < 8) begin
                send(OP_EOL, CHAR_W'($urandom));
                sent++;
            end else if (r < 50) begin
                cut = (r < 40) ? key_len : $urandom_range(key_len);
                for (int unsigned i = 0; i < cut; i++) begin
                    send(OP_TEXT, any_case(key_byte(i)));
                end
                sent += cut;
            end else if (r < 85) begin
                send(OP_TEXT, any_case(key_byte($urandom_range(key_len - 1))));
                sent++;
            end else begin
                send(OP_TEXT, CHAR_W'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        logic [PAT_BITS-1:0] bits;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        bits = '1;
        bits[23:0] = 24'h614261;
        load_pattern(bits, LEN_REG_W'(3));
        send(OP_TEXT, 8'h41);
        send(OP_TEXT, 8'h62);
        send(OP_TEXT, 8'h41);
        send(OP_TEXT, 8'h42);
        send(OP_TEXT, 8'h61);
        send(OP_TEXT, 8'h00);
        send(OP_TEXT, 8'hFF);
        send(OP_TEXT, 8'h40);
        send(OP_TEXT, 8'h5B);
        send(OP_TEXT, 8'h5A);
        send(OP_TEXT, 8'h7A);
        send(OP_EOL, 8'hFF);
        send(OP_TEXT, 8'h61);
        send(OP_TEXT, 8'h42);
        send(OP_TEXT, 8'h61);
        send(OP_EOL, 8'h00);
        send(OP_EOL, 8'h41);
        drain();

        // bytes just outside A-Z must not fold
        bits = '0;
        bits[15:0] = 16'h7B60;
        load_pattern(bits, LEN_REG_W'(2));
        send(OP_TEXT, 8'h40);
        send(OP_TEXT, 8'h5B);
        send(OP_TEXT, 8'h60);
        send(OP_TEXT, 8'h7B);
        send(OP_TEXT, 8'h60);
        send(OP_TEXT, 8'h7B);

        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            pick_pattern(p);
            set_idle(p % IDLE_MODES);
            random_text(ITEMS_PER_PHASE);
        end

        drain();
        set_idle(0);
        bits = '0;
        bits[23:0] = 24'h616161;
        load_pattern(bits, LEN_REG_W'(3));
        send(OP_EOL, 8'h00);
        for (int i = 0; i < LONG_LINE; i++) begin
            send(OP_TEXT, ($urandom_range(15) == 0) ? CH_B : any_case(CH_A));
        end
        repeat (3) send(OP_TEXT, CH_A);
        send(OP_EOL, 8'h00);
        repeat (3) send(OP_TEXT, CH_UPPER_A);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d requests over %0d pattern settings, four idle mixes",
                 request_count, settings_used);
        $display("and a closing line of overlapping copies; %0d results checked, %0d matches.",
                 result_total, hit_total);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ckmp_pkg.sv
rtl/ckmp_front.sv
rtl/ckmp_table.sv
rtl/ckmp_back.sv
rtl/case_insensitive_kmp_matcher.sv
bench/kmp_checker.sv
bench/testbench.sv
